[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the RTL; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

[hdl/tmfp_pkg.sv]
// ----------------------------------------------------------------------------
// tmfp_pkg
// Types and constants of the text message frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tmfp_pkg;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_NUL   = 8'h00;

   typedef enum logic [5:0] {
      PH_CMD   = 6'b000001,
      PH_LINE  = 6'b000010,
      PH_KEY   = 6'b000100,
      PH_VALUE = 6'b001000,
      PH_BODY  = 6'b010000,
      PH_AFTER = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_NOCOLON = 2'd1,
      ERR_EARLY   = 2'd2
   } err_type;

   localparam logic [2:0] CLS_CMD     = 3'd0;
   localparam logic [2:0] CLS_KEY     = 3'd1;
   localparam logic [2:0] CLS_VALUE   = 3'd2;
   localparam logic [2:0] CLS_BODY    = 3'd3;
   localparam logic [2:0] CLS_DELIM   = 3'd4;
   localparam logic [2:0] CLS_DISCARD = 3'd5;

   localparam logic [2:0] ST_BUSY    = 3'd0;
   localparam logic [2:0] ST_OK      = 3'd1;
   localparam logic [2:0] ST_NOCOLON = 3'd2;
   localparam logic [2:0] ST_EARLY   = 3'd3;
   localparam logic [2:0] ST_NO_NL   = 3'd4;

   typedef struct packed {
      logic [2:0] byte_class;
      logic       frame_done;
      logic [2:0] status;
   } label_type;

endpackage

`default_nettype wire

[hdl/text_message_frame_parser.sv]
// ----------------------------------------------------------------------------
// text_message_frame_parser
// Labels each received byte of a text message frame (command, header key,
// header value, body, delimiter, discarded) and reports the frame status on
// the frame's final byte.
//
// Usage:
//   Input channel req_valid/req_ready carries one byte per beat on
//   req_rx_byte. Result channel rsp_valid/rsp_ready returns exactly one beat
//   per input beat: the byte on rsp_out_byte with rsp_byte_class,
//   rsp_frame_done and rsp_status.
//   From input beat to result beat the byte passes one input register,
//   the byte classifier and one result register. Throughput is one byte per
//   cycle while rsp_ready stays high, set by the phase update in the classifier.
//   While rsp_ready is low the result register holds and the input register
//   takes one more byte; req_ready then drops until the result moves on.
//   Synchronous reset empties both registers, returns to the command line
//   phase and clears the pending error.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module text_message_frame_parser (
   input  wire  logic       clock,
   input  wire  logic       reset,
   input  wire  logic       req_valid,
   output       logic       req_ready,
   input  wire  logic [7:0] req_rx_byte,
   output       logic       rsp_valid,
   input  wire  logic       rsp_ready,
   output       logic [7:0] rsp_out_byte,
   output       logic [2:0] rsp_byte_class,
   output       logic       rsp_frame_done,
   output       logic [2:0] rsp_status
);
   import tmfp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   label_type  out_label_ff;
   phase_type  phase_ff, phase_in;
   err_type    err_ff, err_in;

   label_type  label;
   phase_type  phase_next;
   err_type    err_next;
   logic       advance;

   tmfp_classify u_classify (
      .phase      (phase_ff),
      .pend_err   (err_ff),
      .rx_byte    (in_byte_ff),
      .label      (label),
      .phase_next (phase_next),
      .err_next   (err_next)
   );

   // move the held byte into the result register when it is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      phase_in     = phase_ff;
      err_in       = err_ff;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      if (advance) begin
         out_valid_in = 1'b1;
         in_valid_in  = 1'b0;
         phase_in     = phase_next;
         err_in       = err_next;
      end
      if (req_valid && req_ready) in_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_CMD;
         err_ff       <= ERR_NONE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         err_ff       <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_rx_byte;
      if (advance) begin
         out_byte_ff  <= in_byte_ff;
         out_label_ff <= label;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_byte_class = out_label_ff.byte_class;
   assign rsp_frame_done = out_label_ff.frame_done;
   assign rsp_status     = out_label_ff.status;

   `ASSERT_CLK(a_frame_end_rearms, clock, reset, advance && label.frame_done |=> phase_ff == PH_CMD && err_ff == ERR_NONE, "parser not rearmed after frame end")
   `ASSERT_CLK(a_busy_until_done, clock, reset, out_valid_ff && !out_label_ff.frame_done |-> out_label_ff.status == ST_BUSY, "status reported before frame end")
   `ASSERT_CLK(a_discard_is_no_nl, clock, reset, out_valid_ff && out_label_ff.byte_class == CLS_DISCARD |-> out_label_ff.frame_done && out_label_ff.status == ST_NO_NL, "discarded byte without error end")
   `ASSERT_CLK(a_held_byte_kept, clock, reset, in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff), "held input byte lost")

endmodule

`default_nettype wire

[hdl/tmfp_classify.sv]
// ----------------------------------------------------------------------------
// tmfp_classify
// Labels one byte from the current parse phase and pending error, and gives
// the phase and pending error that follow it.
// ----------------------------------------------------------------------------
`default_nettype none

module tmfp_classify (
   input  wire  tmfp_pkg::phase_type phase,
   input  wire  tmfp_pkg::err_type   pend_err,
   input  wire  logic [7:0]          rx_byte,
   output       tmfp_pkg::label_type label,
   output       tmfp_pkg::phase_type phase_next,
   output       tmfp_pkg::err_type   err_next
);
   import tmfp_pkg::*;

   logic is_nl;
   logic is_nul;
   logic is_colon;
   logic set_early;

   assign is_nl    = (rx_byte == CH_NL);
   assign is_nul   = (rx_byte == CH_NUL);
   assign is_colon = (rx_byte == CH_COLON);

   // first error wins
   assign set_early = is_nul && (pend_err == ERR_NONE);

   always_comb begin
      label.byte_class = CLS_DELIM;
      label.frame_done = 1'b0;
      label.status     = ST_BUSY;
      phase_next       = phase;
      err_next         = pend_err;
      case (phase)
         PH_LINE: begin
            if (is_nl) begin
               phase_next = PH_BODY;
            end else if (is_nul) begin
               phase_next = PH_AFTER;
               if (set_early) err_next = ERR_EARLY;
            end else if (is_colon) begin
               phase_next = PH_VALUE;
            end else begin
               label.byte_class = CLS_KEY;
               phase_next       = PH_KEY;
            end
         end
         PH_KEY: begin
            if (is_nl) begin
               phase_next = PH_LINE;
               if (pend_err == ERR_NONE) err_next = ERR_NOCOLON;
            end else if (is_nul) begin
               phase_next = PH_AFTER;
               if (set_early) err_next = ERR_EARLY;
            end else if (is_colon) begin
               phase_next = PH_VALUE;
            end else begin
               label.byte_class = CLS_KEY;
            end
         end
         PH_VALUE: begin
            if (is_nl) begin
               phase_next = PH_LINE;
            end else if (is_nul) begin
               phase_next = PH_AFTER;
               if (set_early) err_next = ERR_EARLY;
            end else begin
               label.byte_class = CLS_VALUE;
            end
         end
         PH_BODY: begin
            if (is_nul) begin
               phase_next = PH_AFTER;
            end else begin
               label.byte_class = CLS_BODY;
            end
         end
         PH_AFTER: begin
            label.frame_done = 1'b1;
            if (is_nl) begin
               case (pend_err)
                  ERR_NOCOLON: label.status = ST_NOCOLON;
                  ERR_EARLY:   label.status = ST_EARLY;
                  default:     label.status = ST_OK;
               endcase
            end else begin
               label.byte_class = CLS_DISCARD;
               label.status     = ST_NO_NL;
            end
            phase_next = PH_CMD;
            err_next   = ERR_NONE;
         end
         default: begin
            // command line
            if (is_nl) begin
               phase_next = PH_LINE;
            end else if (is_nul) begin
               phase_next = PH_AFTER;
               if (set_early) err_next = ERR_EARLY;
            end else begin
               label.byte_class = CLS_CMD;
               phase_next       = PH_CMD;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

[verif/frame_label_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_label_checker
// Follows the frame parser's channels: labels every accepted byte with its own
// copy of the frame state and compares the result beats with the labels in
// order.
// ----------------------------------------------------------------------------
module frame_label_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [7:0]        rsp_out_byte,
   input  logic [2:0]        rsp_byte_class,
   input  logic              rsp_frame_done,
   input  logic [2:0]        rsp_status,
   output int unsigned       mismatch_count,
   output int unsigned       labels_pending
);
   import tmfp_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      label_type  label;
   } byte_label_type;

   phase_type      frame_phase;
   err_type        held_error;
   byte_label_type labels_due[$];
   int unsigned    errors;
   int unsigned    rsp_beats;

   // first error of a frame wins
   function automatic void hold_error(input err_type code);
      if (held_error == ERR_NONE) held_error = code;
   endfunction

   function automatic byte_label_type classify_byte(input logic [7:0] b);
      byte_label_type r;
      r.data             = b;
      r.label.byte_class = CLS_DELIM;
      r.label.frame_done = 1'b0;
      r.label.status     = ST_BUSY;
      case (frame_phase)
         PH_LINE: begin
            if (b == CH_NL) begin
               frame_phase = PH_BODY;
            end else if (b == CH_NUL) begin
               hold_error(ERR_EARLY);
               frame_phase = PH_AFTER;
            end else if (b == CH_COLON) begin
               frame_phase = PH_VALUE;
            end else begin
               r.label.byte_class = CLS_KEY;
               frame_phase = PH_KEY;
            end
         end
         PH_KEY: begin
            if (b == CH_NL) begin
               hold_error(ERR_NOCOLON);
               frame_phase = PH_LINE;
            end else if (b == CH_NUL) begin
               hold_error(ERR_EARLY);
               frame_phase = PH_AFTER;
            end else if (b == CH_COLON) begin
               frame_phase = PH_VALUE;
            end else begin
               r.label.byte_class = CLS_KEY;
            end
         end
         PH_VALUE: begin
            if (b == CH_NL) begin
               frame_phase = PH_LINE;
            end else if (b == CH_NUL) begin
               hold_error(ERR_EARLY);
               frame_phase = PH_AFTER;
            end else begin
               r.label.byte_class = CLS_VALUE;
            end
         end
         PH_BODY: begin
            if (b == CH_NUL) frame_phase = PH_AFTER;
            else r.label.byte_class = CLS_BODY;
         end
         PH_AFTER: begin
            r.label.frame_done = 1'b1;
            if (b == CH_NL) begin
               if (held_error == ERR_NOCOLON) r.label.status = ST_NOCOLON;
               else if (held_error == ERR_EARLY) r.label.status = ST_EARLY;
               else r.label.status = ST_OK;
            end else begin
               // missing final newline overrides any held error
               r.label.byte_class = CLS_DISCARD;
               r.label.status     = ST_NO_NL;
            end
            frame_phase = PH_CMD;
            held_error  = ERR_NONE;
         end
         default: begin
            if (b == CH_NL) begin
               frame_phase = PH_LINE;
            end else if (b == CH_NUL) begin
               hold_error(ERR_EARLY);
               frame_phase = PH_AFTER;
            end else begin
               r.label.byte_class = CLS_CMD;
               frame_phase = PH_CMD;
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      byte_label_type want;
      if (reset) begin
         frame_phase = PH_CMD;
         held_error  = ERR_NONE;
         labels_due.delete();
         errors      = 0;
         rsp_beats   = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_beats++;
            if (labels_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: result beat %0d (byte %h) with no byte outstanding",
                           $time, rsp_beats, rsp_out_byte);
            end else begin
               want = labels_due.pop_front();
               if (rsp_out_byte !== want.data ||
                   rsp_byte_class !== want.label.byte_class ||
                   rsp_frame_done !== want.label.frame_done ||
                   rsp_status !== want.label.status) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: beat %0d mismatch: expected byte=%h class=%0d ",
                              $time, rsp_beats, want.data, want.label.byte_class,
                              "done=%0d status=%0d, ",
                              want.label.frame_done, want.label.status,
                              "got byte=%h class=%0d done=%0d status=%0d",
                              rsp_out_byte, rsp_byte_class, rsp_frame_done,
                              rsp_status);
               end
            end
         end
         if (req_valid && req_ready) labels_due.push_back(classify_byte(req_rx_byte));
      end
      mismatch_count <= errors;
      labels_pending <= labels_due.size();
   end

endmodule

[verif/text_message_frame_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_message_frame_parser_tb
// Feeds the frame parser directed frames, then random frames (mostly well
// formed, some broken, some noise), mostly with random gaps on both
// channels; the label checker beside the block judges every result beat.
// ----------------------------------------------------------------------------
module text_message_frame_parser_tb;
   import tmfp_pkg::*;

   typedef logic [7:0] byte_seq_type[$];

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned TAIL_CYCLES = 8;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_ready   = 1'b0;
   logic        no_gaps     = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [7:0]  rsp_out_byte;
   logic [2:0]  rsp_byte_class;
   logic        rsp_frame_done;
   logic [2:0]  rsp_status;
   int unsigned stall_left  = 0;
   int unsigned idle_cycles = 0;
   int unsigned bytes_sent  = 0;
   int unsigned mismatch_count;
   int unsigned labels_pending;

   text_message_frame_parser u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_class (rsp_byte_class),
      .rsp_frame_done (rsp_frame_done),
      .rsp_status     (rsp_status)
   );

   frame_label_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_class (rsp_byte_class),
      .rsp_frame_done (rsp_frame_done),
      .rsp_status     (rsp_status),
      .mismatch_count (mismatch_count),
      .labels_pending (labels_pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned gap_length();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (no_gaps) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(3) == 0) stall_left <= gap_length();
      end
   end

   // end the run when neither channel moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [7:0] text_byte(input logic colon_ok);
      logic [7:0] b;
      if (colon_ok && $urandom_range(9) == 0) return CH_COLON;
      do b = 8'($urandom_range(255));
      while (b == CH_NL || b == CH_NUL || b == CH_COLON);
      return b;
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(3))
         0: return CH_NUL;
         1: return CH_NL;
         2: return CH_COLON;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic byte_seq_type build_frame();
      byte_seq_type f;
      int unsigned mode;
      int unsigned cut;
      logic [7:0] b;
      mode = $urandom_range(99);
      if (mode < 6) begin
         repeat ($urandom_range(1, 12)) f.push_back(noise_byte());
         return f;
      end
      repeat ($urandom_range(0, 6)) f.push_back(text_byte(1'b1));
      f.push_back(CH_NL);
      repeat ($urandom_range(0, 3)) begin
         repeat ($urandom_range(1, 5)) f.push_back(text_byte(1'b0));
         // header line without colon now and then
         if (!(mode < 12 && $urandom_range(1) == 0)) begin
            f.push_back(CH_COLON);
            repeat ($urandom_range(0, 6)) f.push_back(text_byte(1'b1));
         end
         f.push_back(CH_NL);
      end
      f.push_back(CH_NL);
      repeat ($urandom_range(0, 8)) begin
         if ($urandom_range(7) == 0) f.push_back(CH_NL);
         else f.push_back(8'($urandom_range(1, 255)));
      end
      f.push_back(CH_NUL);
      f.push_back(CH_NL);
      if (mode >= 12 && mode < 18) begin
         // cut short by an early NUL
         cut = $urandom_range(0, f.size() - 3);
         f = f[0:cut];
         f.push_back(CH_NUL);
         f.push_back(CH_NL);
      end else if (mode >= 18 && mode < 22) begin
         do b = 8'($urandom_range(255));
         while (b == CH_NL);
         f[f.size() - 1] = b;
      end
      return f;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = no_gaps ? 0 : gap_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock);
      while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_seq(input byte_seq_type s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   task automatic run_frames(input int unsigned byte_target);
      while (bytes_sent < byte_target) send_seq(build_frame());
   endtask

   // hold the sender until every outstanding label has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock);
      while (labels_pending != 0);
   endtask

   initial begin
      byte_seq_type seq;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // clean frame: colon inside a value, blank line, all-ones body byte
      seq = '{8'h43, CH_NL, 8'h6B, CH_COLON, 8'h76, CH_COLON, CH_NL, CH_NL,
              8'hFF, CH_NUL, CH_NL};
      send_seq(seq);
      // NUL on the command line, then no newline after it
      seq = '{CH_NUL, 8'h7F};
      send_seq(seq);
      // header without colon, later NUL before blank line: first error kept
      seq = '{CH_NL, 8'h6B, CH_NL, CH_NUL, CH_NL};
      send_seq(seq);
      // empty key, NUL inside the value
      seq = '{CH_NL, CH_COLON, CH_NUL, CH_NL};
      send_seq(seq);
      // NUL inside a key
      seq = '{CH_NL, 8'h6B, CH_NUL, CH_NL};
      send_seq(seq);

      run_frames(400);
      no_gaps <= 1'b1;
      run_frames(650);
      no_gaps <= 1'b0;
      wait_for_results();
      run_frames(1026);
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/tmfp_pkg.sv
hdl/tmfp_classify.sv
hdl/text_message_frame_parser.sv
verif/frame_label_checker.sv
verif/text_message_frame_parser_tb.sv
